>>> hw/rtl/ems_pkg.sv
// types, codes and the floor sensor helper for the elevator motor sequencer
// used by ems_step and elevator_motor_sequencer; no dependencies

package ems_pkg;

    // number of floors served, ground is floor 0
    localparam int NUM_FLOORS = 4;

    typedef enum logic {
        OP_GOTO = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        SPD_STOP = 2'd0,
        SPD_SLOW = 2'd1,
        SPD_FAST = 2'd2
    } speed_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] goal_floor;
        logic [1:0] cab_floor;
        logic [3:0] up_sensors_n;
        logic [3:0] down_sensors_n;
    } in_item_t;

    typedef struct packed {
        dir_t   motor_direction;
        speed_t motor_speed;
        logic   running;
        logic   accepted;
        logic   arrived;
    } out_item_t;

    // sequencer state carried from one beat to the next
    typedef struct packed {
        logic [1:0] start_level;
        logic [1:0] end_level;
        logic       departed;
        dir_t       direction;
        speed_t     speed;
        logic       active;
    } ems_state_t;

    // active-low approach sensors; ground has only up, top floor only down
    function automatic logic floor_sensed(input logic [1:0] level,
                                          input logic [3:0] up_n,
                                          input logic [3:0] down_n);
        logic up_on;
        logic down_on;
        up_on   = ~up_n[level];
        down_on = ~down_n[level];
        if ({30'd0, level} == 32'(NUM_FLOORS - 1)) begin
            return down_on;
        end else if (level == 2'd0) begin
            return up_on;
        end else begin
            return up_on | down_on;
        end
    endfunction

endpackage

>>> hw/rtl/ems_step.sv
// next-state and result logic for one beat of the motor sequencer
// depends on ems_pkg

module ems_step
    import ems_pkg::*;
(
    input  in_item_t   item,
    input  ems_state_t cur_state,
    output ems_state_t next_state,
    output out_item_t  result
);

    dir_t goto_dir;
    logic goto_ok;
    logic accepted;
    logic arrived;
    logic start_sensed;
    logic end_sensed;

    always_comb begin
        if (item.cab_floor < item.goal_floor) begin
            goto_dir = DIR_UP;
        end else if (item.cab_floor > item.goal_floor) begin
            goto_dir = DIR_DOWN;
        end else begin
            goto_dir = DIR_NONE;
        end
    end

    assign goto_ok = (cur_state.direction == DIR_NONE) || (cur_state.direction == goto_dir);

    assign start_sensed = floor_sensed(cur_state.start_level,
                                       item.up_sensors_n, item.down_sensors_n);
    assign end_sensed   = floor_sensed(cur_state.end_level,
                                       item.up_sensors_n, item.down_sensors_n);

    always_comb begin
        next_state = cur_state;
        accepted   = 1'b0;
        arrived    = 1'b0;
        case (item.op)
            OP_GOTO: begin
                // start and end are taken even if the move is refused
                next_state.start_level = item.cab_floor;
                next_state.end_level   = item.goal_floor;
                if (goto_ok) begin
                    next_state.direction = goto_dir;
                    next_state.active    = 1'b1;
                    accepted             = 1'b1;
                end
            end
            OP_TICK: begin
                if (cur_state.active) begin
                    if (item.cab_floor == cur_state.end_level) begin
                        next_state.speed     = SPD_STOP;
                        next_state.direction = DIR_NONE;
                        next_state.departed  = 1'b0;
                        next_state.active    = 1'b0;
                        arrived              = 1'b1;
                    end else if (!cur_state.departed) begin
                        next_state.departed = start_sensed;
                        next_state.speed    = start_sensed ? SPD_FAST : SPD_SLOW;
                    end else if (end_sensed) begin
                        next_state.speed = SPD_SLOW;
                    end
                end
            end
            default: begin
                next_state = cur_state;
            end
        endcase
    end

    always_comb begin
        result.motor_direction = next_state.direction;
        result.motor_speed     = next_state.speed;
        result.running         = next_state.active;
        result.accepted        = accepted;
        result.arrived         = arrived;
    end

endmodule

>>> hw/rtl/elevator_motor_sequencer.sv
// elevator motor sequencer: input register, step logic, result register
// depends on ems_pkg and ems_step
//
// Each input beat is a goto request or a monitor tick and gives exactly one
// result beat carrying the motor direction, speed and running flag after the
// beat, plus accepted (goto taken) and arrived (tick reached the end floor).
// A beat is captured in an input register, evaluated against the sequencer
// state by a short block of compares and muxes in ems_step, and the result
// lands in an output register. One beat is accepted per cycle while the
// output side takes results; a result beat is loaded into the output register
// as its beat leaves the input register, which stalls while an untaken result
// waits. The input and output registers form a two-deep pipeline, so a
// waiting result does not block the next input beat from being captured while
// the input register is empty. Sequencer state updates as a beat moves from
// the input register into the result register, so beats are applied in order.

module elevator_motor_sequencer
    import ems_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,

    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,

    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    // input stage
    logic       in_valid_reg;
    logic       in_valid_next;
    in_item_t   in_item_reg;

    // result stage
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;

    // sequencer state
    ems_state_t state_reg;
    ems_state_t state_next;
    out_item_t  step_result;

    logic       advance;
    logic       s_fire;

    // a captured beat moves on when the result slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    ems_step u_step (
        .item       (in_item_reg),
        .cur_state  (state_reg),
        .next_state (state_next),
        .result     (step_result)
    );

    always_comb begin
        in_valid_next  = s_fire || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.start_level <= 2'd0;
            state_reg.end_level   <= 2'd0;
            state_reg.departed    <= 1'b0;
            state_reg.direction   <= DIR_NONE;
            state_reg.speed       <= SPD_STOP;
            state_reg.active      <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // a pending result always mirrors the current sequencer state
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_item_reg.running == state_reg.active)
                       && (out_item_reg.motor_direction == state_reg.direction)
                       && (out_item_reg.motor_speed == state_reg.speed))
        else $error("result beat disagrees with sequencer state");

    // idle sequencer holds the motor stopped with no direction
    assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.active |-> (state_reg.speed == SPD_STOP)
                           && (state_reg.direction == DIR_NONE)
                           && !state_reg.departed)
        else $error("idle sequencer with motor not at rest");

    // once departed the motor is never stopped
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.departed |-> (state_reg.speed != SPD_STOP))
        else $error("departed while motor stopped");

    // a beat never reports both a goto accept and an arrival
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_item_reg.accepted && out_item_reg.arrived))
        else $error("accepted and arrived in one beat");

    // an advancing beat always lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced beat lost");

endmodule
